### rtl/core/mep_pkg.sv
// mep_pkg: shared types and constants for the mandelbrot escape-time pixel unit
// holds widths, register indexes, sequencer states and the multiplier/accumulator op tags
// no dependencies
package mep_pkg;

    // field widths
    localparam int C_CFG_W       = 40;
    localparam int C_STEP_W      = 39;
    localparam int C_ZOOM_W      = 24;
    localparam int C_ITER_W      = 16;
    localparam int C_BAIL_W      = 5;
    localparam int C_COORD_W     = 11;
    localparam int C_COLOR_W     = 8;
    localparam int C_CFG_IDX_W   = 3;
    localparam int C_IN_TDATA_W  = 24;
    localparam int C_OUT_TDATA_W = 64;

    // fixed point: fraction bits of a point coordinate
    localparam int C_FRAC        = 34;
    // fraction bits of inv_zoom
    localparam int C_ZOOM_FRAC   = 16;

    // internal datapath widths
    localparam int C_PT_W        = 52;          // signed point coordinate
    localparam int C_HALF_W      = C_PT_W / 2;  // multiplier operand
    localparam int C_PROD_W      = 2 * C_HALF_W;
    localparam int C_ACC_W       = 2 * C_PT_W;  // exact squares and their sums
    localparam int C_NUM_W       = 48;          // colour numerator / divisor
    localparam int C_SEQ_W       = 3;
    localparam int C_BIT_W       = 3;

    // reset values of the configuration registers
    localparam logic [C_ZOOM_W-1:0] C_INV_ZOOM_RST = 24'd262144;
    localparam logic [C_ITER_W-1:0] C_MAX_ITER_RST = 16'd1500;
    localparam logic [C_BAIL_W-1:0] C_BAILOUT_RST  = 5'd4;

    // 255 squared, scales the iteration count for the root search
    localparam logic [C_ITER_W-1:0]  C_RB_SCALE = 16'd65025;
    localparam logic [C_COLOR_W-1:0] C_FULL     = 8'd255;

    typedef enum logic [C_CFG_IDX_W-1:0] {
        CFG_X_LOW    = 3'd0,
        CFG_Y_LOW    = 3'd1,
        CFG_X_STEP   = 3'd2,
        CFG_Y_STEP   = 3'd3,
        CFG_INV_ZOOM = 3'd4,
        CFG_MAX_ITER = 3'd5,
        CFG_BAILOUT  = 3'd6
    } t_cfg_idx;

    // left shift applied to a partial product before accumulation
    typedef enum logic [1:0] {
        SH_0,
        SH_HALF,
        SH_HALF1,
        SH_FULL
    } t_shf;

    typedef struct packed {
        logic valid;
        t_shf shf;
        logic neg0;
        logic en1;
        logic neg1;
    } t_acc_tag;

    typedef struct packed {
        logic [C_HALF_W-1:0] x;
        logic [C_HALF_W-1:0] y;
        t_acc_tag            tag;
    } t_mul_req;

    typedef struct packed {
        logic clr0;
        logic clr1;
    } t_acc_clr;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CX,
        S_CY,
        S_SQ,
        S_CHECK,
        S_AB,
        S_UPD,
        S_CLASS,
        S_GMUL,
        S_GNUM,
        S_GSAT,
        S_GDIV,
        S_RMUL,
        S_RLIM,
        S_RSQ,
        S_RSCL,
        S_RCMP,
        S_DONE
    } t_state;

endpackage

### rtl/core/mandelbrot_escape_pixel_top.sv
// mandelbrot_escape_pixel_top: escape-time iteration and colour mapping for one pixel
// sequencer around the shared multiplier (mep_mul) and accumulators (mep_acc); uses mep_pkg
//
//  channel     | direction | ports                  | contents (low bit first)
//  ------------+-----------+------------------------+-----------------------------------------
//  config      | in        | i_cfg_we/idx/wdata     | register index 0..6, value in low bits
//  pixel in    | in        | i_s_axis_t*            | pixel_col, pixel_row
//  pixel out   | out       | o_m_axis_t*            | out_col, out_row, red, green, blue, count
//
//  one pixel at a time; each iteration runs ten 26x26 partial products through the one shared
//  multiplier, one a cycle, and an escaped pixel then takes either the green division or the
//  red/blue root search.
//  reset is synchronous; the result sits in an output register, so a stalled result
//  does not block the next pixel until that one finishes too.
module mandelbrot_escape_pixel_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [mep_pkg::C_CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mep_pkg::C_CFG_W-1:0]          i_cfg_wdata,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // [10:0] pixel_col, [21:11] pixel_row, rest zero
    input  logic [mep_pkg::C_IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // [10:0] out_col, [21:11] out_row, [29:22] red, [37:30] green, [45:38] blue,
    // [61:46] iter_count, rest zero
    output logic [mep_pkg::C_OUT_TDATA_W-1:0]    o_m_axis_tdata
);
    import mep_pkg::*;

    // configuration
    logic [C_CFG_W-1:0]   r_x_low;
    logic [C_CFG_W-1:0]   r_y_low;
    logic [C_STEP_W-1:0]  r_x_step;
    logic [C_STEP_W-1:0]  r_y_step;
    logic [C_ZOOM_W-1:0]  r_inv_zoom;
    logic [C_ITER_W-1:0]  r_max_iter;
    logic [C_BAIL_W-1:0]  r_bailout;

    // sequencer and datapath
    t_state               r_state;
    t_state               n_state;
    logic [C_COORD_W-1:0] r_col;
    logic [C_COORD_W-1:0] r_row;
    logic [C_PT_W-1:0]    r_cx;
    logic [C_PT_W-1:0]    r_cy;
    logic [C_PT_W-1:0]    r_a;
    logic [C_PT_W-1:0]    r_b;
    logic [C_PT_W-1:0]    r_ma;
    logic [C_PT_W-1:0]    r_mb;
    logic                 r_sa;
    logic                 r_sb;
    logic [C_ITER_W-1:0]  r_iter;
    logic [C_SEQ_W-1:0]   r_u;
    logic [C_BIT_W-1:0]   r_bit;
    logic [C_COLOR_W-1:0] r_rb;
    logic [C_COLOR_W-1:0] r_grn;
    logic [C_NUM_W-1:0]   r_num;
    logic [C_NUM_W-1:0]   r_den;
    logic                 r_ovalid;
    logic [C_OUT_TDATA_W-1:0] r_otdata;

    t_mul_req             w_req;
    t_acc_clr             w_clr;
    logic [C_PROD_W-1:0]  w_prod;
    t_acc_tag             w_tag;
    logic [C_ACC_W-1:0]   w_acc0;
    logic [C_ACC_W-1:0]   w_acc1;

    logic [C_COORD_W-1:0] w_coord;
    logic [C_STEP_W-1:0]  w_step;
    logic [C_CFG_W-1:0]   w_low;
    logic [C_COORD_W+C_STEP_W-1:0] w_cprod;
    logic [C_PT_W-1:0]    w_cpt;
    logic [C_ACC_W-1:0]   w_lim;
    logic                 w_cont;
    logic [C_PT_W-1:0]    w_a_nxt;
    logic [C_PT_W-1:0]    w_b_nxt;
    logic [C_COLOR_W-1:0] w_trial;
    logic                 w_in_xfer;
    logic                 w_load;
    logic [C_HALF_W-1:0]  w_al;
    logic [C_HALF_W-1:0]  w_ah;
    logic [C_HALF_W-1:0]  w_bl;
    logic [C_HALF_W-1:0]  w_bh;

    function automatic t_mul_req f_req(
        input logic [C_HALF_W-1:0] x,
        input logic [C_HALF_W-1:0] y,
        input t_shf                shf,
        input logic                neg0,
        input logic                en1,
        input logic                neg1
    );
        t_mul_req r;
        r.x         = x;
        r.y         = y;
        r.tag.valid = 1'b1;
        r.tag.shf   = shf;
        r.tag.neg0  = neg0;
        r.tag.en1   = en1;
        r.tag.neg1  = neg1;
        return r;
    endfunction

    mep_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_prod  (w_prod),
        .o_tag   (w_tag)
    );

    mep_acc u_acc (
        .i_clk   (i_clk),
        .i_prod  (w_prod),
        .i_tag   (w_tag),
        .i_clr   (w_clr),
        .o_acc0  (w_acc0),
        .o_acc1  (w_acc1)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_low    <= '0;
            r_y_low    <= '0;
            r_x_step   <= '0;
            r_y_step   <= '0;
            r_inv_zoom <= C_INV_ZOOM_RST;
            r_max_iter <= C_MAX_ITER_RST;
            r_bailout  <= C_BAILOUT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_X_LOW:    r_x_low    <= i_cfg_wdata;
                CFG_Y_LOW:    r_y_low    <= i_cfg_wdata;
                CFG_X_STEP:   r_x_step   <= i_cfg_wdata[C_STEP_W-1:0];
                CFG_Y_STEP:   r_y_step   <= i_cfg_wdata[C_STEP_W-1:0];
                CFG_INV_ZOOM: r_inv_zoom <= i_cfg_wdata[C_ZOOM_W-1:0];
                CFG_MAX_ITER: r_max_iter <= i_cfg_wdata[C_ITER_W-1:0];
                CFG_BAILOUT:  r_bailout  <= i_cfg_wdata[C_BAIL_W-1:0];
                default: ;
            endcase
        end
    end

    // point of the pixel: low edge plus index times step
    assign w_coord = (r_state == S_CX) ? r_col : r_row;
    assign w_step  = (r_state == S_CX) ? r_x_step : r_y_step;
    assign w_low   = (r_state == S_CX) ? r_x_low : r_y_low;
    assign w_cprod = w_coord * w_step;
    assign w_cpt   = {{(C_PT_W - C_CFG_W){w_low[C_CFG_W-1]}}, w_low} + C_PT_W'(w_cprod);

    assign w_al = r_ma[C_HALF_W-1:0];
    assign w_ah = r_ma[C_PT_W-1:C_HALF_W];
    assign w_bl = r_mb[C_HALF_W-1:0];
    assign w_bh = r_mb[C_PT_W-1:C_HALF_W];

    assign w_lim  = C_ACC_W'(r_bailout) << (2 * C_FRAC);
    assign w_cont = (r_iter < r_max_iter) && (w_acc0 <= w_lim);

    // new z: floor shifts back to the point format, then add c
    assign w_a_nxt = C_PT_W'($signed(w_acc1) >>> C_FRAC) + r_cx;
    assign w_b_nxt = C_PT_W'($signed(w_acc0) >>> (C_FRAC - 1)) + r_cy;

    assign w_trial = r_rb | (C_COLOR_W'(1) << r_bit);

    assign w_in_xfer = i_s_axis_tvalid && o_s_axis_tready;
    assign w_load    = (r_state == S_DONE) && (!r_ovalid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and multiplier issue
    always_comb begin
        n_state = r_state;
        w_req   = '0;
        w_clr   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = S_CX;
                end
            end
            S_CX: n_state = S_CY;
            S_CY: begin
                w_clr   = '{clr0: 1'b1, clr1: 1'b1};
                n_state = S_SQ;
            end
            S_SQ: begin
                // r_u 0 latches magnitudes, r_u 1..6 issue, r_u 7 drains the last product
                unique case (r_u)
                    3'd1: w_req = f_req(w_al, w_al, SH_0,     1'b0, 1'b1, 1'b0);
                    3'd2: w_req = f_req(w_al, w_ah, SH_HALF1, 1'b0, 1'b1, 1'b0);
                    3'd3: w_req = f_req(w_ah, w_ah, SH_FULL,  1'b0, 1'b1, 1'b0);
                    3'd4: w_req = f_req(w_bl, w_bl, SH_0,     1'b0, 1'b1, 1'b1);
                    3'd5: w_req = f_req(w_bl, w_bh, SH_HALF1, 1'b0, 1'b1, 1'b1);
                    3'd6: w_req = f_req(w_bh, w_bh, SH_FULL,  1'b0, 1'b1, 1'b1);
                    default: w_req = '0;
                endcase
                if (r_u == 3'd7) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                w_clr.clr0 = 1'b1;
                n_state    = w_cont ? S_AB : S_CLASS;
            end
            S_AB: begin
                unique case (r_u)
                    3'd0: w_req = f_req(w_al, w_bl, SH_0,    r_sa ^ r_sb, 1'b0, 1'b0);
                    3'd1: w_req = f_req(w_al, w_bh, SH_HALF, r_sa ^ r_sb, 1'b0, 1'b0);
                    3'd2: w_req = f_req(w_ah, w_bl, SH_HALF, r_sa ^ r_sb, 1'b0, 1'b0);
                    3'd3: w_req = f_req(w_ah, w_bh, SH_FULL, r_sa ^ r_sb, 1'b0, 1'b0);
                    default: w_req = '0;
                endcase
                if (r_u == 3'd4) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                w_clr   = '{clr0: 1'b1, clr1: 1'b1};
                n_state = S_SQ;
            end
            S_CLASS: begin
                if (r_iter == r_max_iter) begin
                    n_state = S_DONE;
                end else if ({r_iter, 1'b0} > {1'b0, r_max_iter}) begin
                    n_state = S_GMUL;
                end else begin
                    n_state = S_RMUL;
                end
            end
            S_GMUL: begin
                w_req.x = C_HALF_W'(r_iter);
                w_req.y = C_HALF_W'(r_inv_zoom);
                n_state = S_GNUM;
            end
            S_GNUM: n_state = S_GSAT;
            S_GSAT: n_state = (r_num >= r_den) ? S_DONE : S_GDIV;
            S_GDIV: begin
                if (r_bit == '0) begin
                    n_state = S_DONE;
                end
            end
            S_RMUL: begin
                w_req.x = C_HALF_W'(r_iter);
                w_req.y = C_HALF_W'(C_RB_SCALE);
                n_state = S_RLIM;
            end
            S_RLIM: n_state = S_RSQ;
            S_RSQ: begin
                w_req.x = C_HALF_W'(w_trial);
                w_req.y = C_HALF_W'(w_trial);
                n_state = S_RSCL;
            end
            S_RSCL: begin
                w_req.x = C_HALF_W'(w_prod[C_ITER_W-1:0]);
                w_req.y = C_HALF_W'(r_max_iter);
                n_state = S_RCMP;
            end
            S_RCMP: n_state = (r_bit == '0) ? S_DONE : S_RSQ;
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    r_col <= i_s_axis_tdata[C_COORD_W-1:0];
                    r_row <= i_s_axis_tdata[2*C_COORD_W-1:C_COORD_W];
                end
            end
            S_CX: begin
                r_cx <= w_cpt;
                r_a  <= w_cpt;
            end
            S_CY: begin
                r_cy   <= w_cpt;
                r_b    <= w_cpt;
                r_iter <= '0;
                r_u    <= '0;
            end
            S_SQ: begin
                if (r_u == '0) begin
                    r_sa <= r_a[C_PT_W-1];
                    r_sb <= r_b[C_PT_W-1];
                    r_ma <= r_a[C_PT_W-1] ? (-r_a) : r_a;
                    r_mb <= r_b[C_PT_W-1] ? (-r_b) : r_b;
                end
                r_u <= r_u + 1'b1;
            end
            S_CHECK: r_u <= '0;
            S_AB:    r_u <= r_u + 1'b1;
            S_UPD: begin
                r_a    <= w_a_nxt;
                r_b    <= w_b_nxt;
                r_iter <= r_iter + 1'b1;
                r_u    <= '0;
            end
            S_CLASS: begin
                r_grn <= '0;
                if (r_iter == r_max_iter) begin
                    r_rb <= '0;
                end else begin
                    r_rb <= C_FULL;
                end
            end
            S_GMUL: ;
            S_GNUM: begin
                // i * inv_zoom * 255 over max_iter scaled by the zoom fraction
                r_num <= (C_NUM_W'(w_prod) << C_COLOR_W) - C_NUM_W'(w_prod);
                r_den <= C_NUM_W'(r_max_iter) << (C_ZOOM_FRAC + C_COLOR_W);
            end
            S_GSAT: begin
                if (r_num >= r_den) begin
                    r_grn <= C_FULL;
                end else begin
                    r_den <= r_den >> 1;
                    r_bit <= C_BIT_W'(C_COLOR_W - 1);
                end
            end
            S_GDIV: begin
                if (r_num >= r_den) begin
                    r_num        <= r_num - r_den;
                    r_grn[r_bit] <= 1'b1;
                end
                r_den <= r_den >> 1;
                r_bit <= r_bit - 1'b1;
            end
            S_RMUL: ;
            S_RLIM: begin
                r_num <= C_NUM_W'(w_prod);
                r_bit <= C_BIT_W'(C_COLOR_W - 1);
                r_rb  <= '0;
            end
            S_RSQ:  ;
            S_RSCL: ;
            S_RCMP: begin
                // keep the trial bit while trial^2 * max_iter stays within 65025 * i
                if (C_NUM_W'(w_prod) <= r_num) begin
                    r_rb <= w_trial;
                end
                r_bit <= r_bit - 1'b1;
            end
            S_DONE: begin
                if (w_load) begin
                    r_otdata <= {2'b00, r_iter, r_rb, r_grn, r_rb, r_row, r_col};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_otdata;

`ifndef SYNTHESIS
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQ) |-> (r_iter <= r_max_iter))
        else $error("iteration count ran past max_iter");

    a_tag_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tag.valid |-> ((r_state == S_SQ) || (r_state == S_AB)))
        else $error("partial product accumulated outside the iteration phases");

    a_div_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GDIV) |-> (r_num < (r_den << 1)))
        else $error("green division remainder out of range");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == S_CX))
        else $error("input transfer did not start a pixel");
`endif

endmodule

### rtl/core/mep_mul.sv
// mep_mul: shared unsigned multiplier with registered product
// carries the accumulate tag alongside the product; depends on mep_pkg
module mep_mul (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mep_pkg::t_mul_req               i_req,
    output logic [mep_pkg::C_PROD_W-1:0]    o_prod,
    output mep_pkg::t_acc_tag               o_tag
);
    import mep_pkg::*;

    logic [C_PROD_W-1:0] r_prod;
    t_acc_tag            r_tag;

    always_ff @(posedge i_clk) begin
        r_prod <= i_req.x * i_req.y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= i_req.tag;
        end
    end

    assign o_prod = r_prod;
    assign o_tag  = r_tag;

endmodule

### rtl/core/mep_acc.sv
// mep_acc: two wide accumulators fed by shifted partial products
// acc0 builds |z|^2 then re*im, acc1 builds re^2 - im^2; depends on mep_pkg
module mep_acc (
    input  logic                            i_clk,
    input  logic [mep_pkg::C_PROD_W-1:0]    i_prod,
    input  mep_pkg::t_acc_tag               i_tag,
    input  mep_pkg::t_acc_clr               i_clr,
    output logic [mep_pkg::C_ACC_W-1:0]     o_acc0,
    output logic [mep_pkg::C_ACC_W-1:0]     o_acc1
);
    import mep_pkg::*;

    logic [C_ACC_W-1:0] r_acc0;
    logic [C_ACC_W-1:0] r_acc1;
    logic [C_ACC_W-1:0] w_sp;

    always_comb begin
        unique case (i_tag.shf)
            SH_0:     w_sp = C_ACC_W'(i_prod);
            SH_HALF:  w_sp = C_ACC_W'(i_prod) << C_HALF_W;
            SH_HALF1: w_sp = C_ACC_W'(i_prod) << (C_HALF_W + 1);  // cross term, doubled
            SH_FULL:  w_sp = C_ACC_W'(i_prod) << (2 * C_HALF_W);
            default:  w_sp = C_ACC_W'(i_prod);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_clr.clr0) begin
            r_acc0 <= '0;
        end else if (i_tag.valid) begin
            r_acc0 <= i_tag.neg0 ? (r_acc0 - w_sp) : (r_acc0 + w_sp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_clr.clr1) begin
            r_acc1 <= '0;
        end else if (i_tag.valid && i_tag.en1) begin
            r_acc1 <= i_tag.neg1 ? (r_acc1 - w_sp) : (r_acc1 + w_sp);
        end
    end

    assign o_acc0 = r_acc0;
    assign o_acc1 = r_acc1;

endmodule

### bench/tb_top.sv
// tb_top: self-checking bench for mandelbrot_escape_pixel_top
// directed table then random frames, each pixel checked against an escape-time predictor
// depends on mep_pkg and the rtl of the pixel unit
`timescale 1ns / 1ps

module tb_top;
    import mep_pkg::*;

    localparam int SCRIPT_ROWS   = 44;
    localparam int RANDOM_PIXELS = 400;

    typedef struct packed {
        logic [C_CFG_W-1:0]   x_low;
        logic [C_CFG_W-1:0]   y_low;
        logic [C_STEP_W-1:0]  x_step;
        logic [C_STEP_W-1:0]  y_step;
        logic [C_ZOOM_W-1:0]  inv_zoom;
        logic [C_ITER_W-1:0]  max_iter;
        logic [C_BAIL_W-1:0]  bailout;
    } t_plane;

    // same layout as o_m_axis_tdata[61:0]
    typedef struct packed {
        logic [C_ITER_W-1:0]  count;
        logic [C_COLOR_W-1:0] blue;
        logic [C_COLOR_W-1:0] green;
        logic [C_COLOR_W-1:0] red;
        logic [C_COORD_W-1:0] row;
        logic [C_COORD_W-1:0] col;
    } t_pixel_out;

    typedef struct packed {
        logic [C_COLOR_W-1:0] red;
        logic [C_COLOR_W-1:0] green;
        logic [C_COLOR_W-1:0] blue;
        logic [C_ITER_W-1:0]  count;
    } t_shade;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_PIX,
        ROW_KNOWN
    } t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        t_cfg_idx             idx;
        logic [C_CFG_W-1:0]   value;
        logic [C_COORD_W-1:0] col;
        logic [C_COORD_W-1:0] row;
        t_shade               shade;
    } t_step_row;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [C_CFG_IDX_W-1:0]   i_cfg_idx;
    logic [C_CFG_W-1:0]       i_cfg_wdata;
    logic                     i_s_axis_tvalid;
    logic                     o_s_axis_tready;
    logic [C_IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                     o_m_axis_tvalid;
    logic                     i_m_axis_tready;
    logic [C_OUT_TDATA_W-1:0] o_m_axis_tdata;

    t_plane     plane;
    t_pixel_out pending_px[$];
    t_step_row  script [0:SCRIPT_ROWS-1];
    int         faults = 0;
    bit         calm = 1'b0;

    mandelbrot_escape_pixel_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // exact signed 64x64 product
    function automatic logic [127:0] wide_mul(input logic [63:0] a, input logic [63:0] b);
        logic signed [127:0] sa;
        logic signed [127:0] sb;
        sa = {{64{a[63]}}, a};
        sb = {{64{b[63]}}, b};
        return sa * sb;
    endfunction

    function automatic t_pixel_out escape_pixel(input logic [C_COORD_W-1:0] col,
                                                input logic [C_COORD_W-1:0] row);
        logic [63:0]  cx, cy, za, zb, nxt, n, grn, k;
        logic [127:0] aa, bb, ab, diff, lim;
        t_pixel_out   res;
        cx = {{(64-C_CFG_W){plane.x_low[C_CFG_W-1]}}, plane.x_low}
             + 64'(col) * 64'(plane.x_step);
        cy = {{(64-C_CFG_W){plane.y_low[C_CFG_W-1]}}, plane.y_low}
             + 64'(row) * 64'(plane.y_step);
        lim = 128'(plane.bailout) << (2 * C_FRAC);
        za = cx;
        zb = cy;
        n = 0;
        aa = wide_mul(za, za);
        bb = wide_mul(zb, zb);
        while (n < 64'(plane.max_iter) && (aa + bb) <= lim) begin
            ab = wide_mul(za, zb);
            diff = aa - bb;
            nxt = diff[C_FRAC +: 64] + cx;
            // 2ab folded into the shift
            zb = ab[C_FRAC-1 +: 64] + cy;
            za = nxt;
            n++;
            aa = wide_mul(za, za);
            bb = wide_mul(zb, zb);
        end
        res = '0;
        res.col = col;
        res.row = row;
        res.count = n[C_ITER_W-1:0];
        if (n == 64'(plane.max_iter)) begin
            res.red = '0;
        end else if (2 * n > 64'(plane.max_iter)) begin
            grn = (n * 64'(plane.inv_zoom) * 64'(C_FULL)) / (64'(plane.max_iter) << C_ZOOM_FRAC);
            if (grn > 64'(C_FULL)) grn = 64'(C_FULL);
            res.red = C_FULL;
            res.blue = C_FULL;
            res.green = grn[C_COLOR_W-1:0];
        end else begin
            // floor(255*sqrt(count/max_iter)) by search
            k = 0;
            while (k < 64'(C_FULL) &&
                   (k + 1) * (k + 1) * 64'(plane.max_iter) <= 64'(C_RB_SCALE) * n) k++;
            res.red = k[C_COLOR_W-1:0];
            res.blue = k[C_COLOR_W-1:0];
        end
        return res;
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [C_CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_X_LOW:    plane.x_low    = value;
            CFG_Y_LOW:    plane.y_low    = value;
            CFG_X_STEP:   plane.x_step   = value[C_STEP_W-1:0];
            CFG_Y_STEP:   plane.y_step   = value[C_STEP_W-1:0];
            CFG_INV_ZOOM: plane.inv_zoom = value[C_ZOOM_W-1:0];
            CFG_MAX_ITER: plane.max_iter = value[C_ITER_W-1:0];
            CFG_BAILOUT:  plane.bailout  = value[C_BAIL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_pixel(input logic [C_COORD_W-1:0] col, input logic [C_COORD_W-1:0] row,
                              input bit known, input t_shade shade);
        int         gap;
        t_pixel_out want;
        gap = calm ? 0 : $urandom_range(0, 4);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata = {2'b00, row, col};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        want = escape_pixel(col, row);
        if (known) begin
            want.red = shade.red;
            want.green = shade.green;
            want.blue = shade.blue;
            want.count = shade.count;
        end
        pending_px.push_back(want);
    endtask

    // drop valid and let every pixel in flight drain out
    task automatic finish_frame();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (pending_px.size() != 0) @(posedge i_clk);
    endtask

    task automatic pick_settings(input bit slow);
        logic [C_CFG_W-1:0]  noise;
        logic [C_ITER_W-1:0] limit;
        noise = {8'($urandom), $urandom};
        if (slow) limit = 16'($urandom_range(200, 1500));
        else if ($urandom_range(0, 15) == 0) limit = '0;
        else limit = 16'($urandom_range(1, 48));
        if (slow || $urandom_range(0, 9) < 7) begin
            // window over the set: x from -2.5, y from -1.5
            write_reg(CFG_X_LOW, 40'hF6_0000_0000 + 40'($urandom) * 40'd8);
            write_reg(CFG_Y_LOW, 40'hFA_0000_0000 + 40'($urandom_range(0, 32'hBFFF_FFFF)) * 40'd8);
            write_reg(CFG_X_STEP, 40'($urandom_range(32'h1_0000, 32'h100_0000)));
            write_reg(CFG_Y_STEP, 40'($urandom_range(32'h1_0000, 32'h100_0000)));
            write_reg(CFG_INV_ZOOM, 40'($urandom_range(0, 32'hFF_FFFF)));
            write_reg(CFG_MAX_ITER, 40'(limit));
            if ($urandom_range(0, 7) == 0) write_reg(CFG_BAILOUT, 40'($urandom_range(0, 31)));
            else write_reg(CFG_BAILOUT, 40'($urandom_range(1, 16)));
        end else begin
            // raw values, upper write bits of narrow registers carry junk
            write_reg(CFG_X_LOW, {8'($urandom), $urandom});
            write_reg(CFG_Y_LOW, {8'($urandom), $urandom});
            write_reg(CFG_X_STEP, {8'($urandom), $urandom});
            write_reg(CFG_Y_STEP, {8'($urandom), $urandom});
            write_reg(CFG_INV_ZOOM, {8'($urandom), $urandom});
            write_reg(CFG_MAX_ITER, {noise[C_CFG_W-1:C_ITER_W], limit});
            write_reg(CFG_BAILOUT, {noise[C_CFG_W-1:C_BAIL_W], 5'($urandom)});
        end
    endtask

    task automatic cmp_field(input string tag, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, tag, want, got);
            faults++;
        end
    endtask

    always @(posedge i_clk) begin : pixel_check
        t_pixel_out got;
        t_pixel_out want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_pixel_out'(o_m_axis_tdata[61:0]);
            if (pending_px.size() == 0) begin
                $display("%0t: pixel transfer with nothing expected, tdata %h",
                         $time, o_m_axis_tdata);
                faults++;
            end else begin
                want = pending_px.pop_front();
                cmp_field("out_col", want.col, got.col);
                cmp_field("out_row", want.row, got.row);
                cmp_field("red", want.red, got.red);
                cmp_field("green", want.green, got.green);
                cmp_field("blue", want.blue, got.blue);
                cmp_field("iter_count", want.count, got.count);
                cmp_field("tdata pad", 0, o_m_axis_tdata[63:62]);
            end
        end
    end

    // result side backpressure
    initial begin : sink
        int hold;
        i_m_axis_tready = 1'b0;
        hold = $urandom_range(0, 4);
        forever begin
            @(negedge i_clk);
            i_m_axis_tready = (hold == 0);
            @(posedge i_clk);
            if (hold > 0) hold--;
            else if (o_m_axis_tvalid) hold = calm ? 0 : $urandom_range(0, 4);
        end
    end

    initial begin : stimulus
        int        n;
        int        sent;
        int        lot;
        int        phase;
        t_step_row r;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_X_LOW;
        i_cfg_wdata = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        plane = '{x_low: '0, y_low: '0, x_step: '0, y_step: '0, inv_zoom: C_INV_ZOOM_RST,
                  max_iter: C_MAX_ITER_RST, bailout: C_BAILOUT_RST};
        script = '{
            // reset view: c = 0 never escapes
            '{ROW_KNOWN, CFG_X_LOW, 40'h0, 11'd0, 11'd0, '{8'd0, 8'd0, 8'd0, 16'd1500}},
            '{ROW_KNOWN, CFG_X_LOW, 40'h0, 11'd2047, 11'd2047, '{8'd0, 8'd0, 8'd0, 16'd1500}},
            '{ROW_CFG, CFG_MAX_ITER, 40'd20, 11'd0, 11'd0, '0},
            // far points fail the first test
            '{ROW_CFG, CFG_X_LOW, 40'h80_0000_0000, 11'd0, 11'd0, '0},
            '{ROW_KNOWN, CFG_X_LOW, 40'h0, 11'd0, 11'd0, '{8'd0, 8'd0, 8'd0, 16'd0}},
            '{ROW_CFG, CFG_X_LOW, 40'h7F_FFFF_FFFF, 11'd0, 11'd0, '0},
            '{ROW_CFG, CFG_Y_LOW, 40'h80_0000_0000, 11'd0, 11'd0, '0},
            '{ROW_KNOWN, CFG_X_LOW, 40'h0, 11'd2047, 11'd2047, '{8'd0, 8'd0, 8'd0, 16'd0}},
            '{ROW_CFG, CFG_MAX_ITER, 40'hFFFF, 11'd0, 11'd0, '0},
            '{ROW_KNOWN, CFG_X_LOW, 40'h0, 11'd1, 11'd2, '{8'd0, 8'd0, 8'd0, 16'd0}},
            // zero iteration limit is black at once
            '{ROW_CFG, CFG_MAX_ITER, 40'd0, 11'd0, 11'd0, '0},
            '{ROW_CFG, CFG_X_LOW, 40'h0, 11'd0, 11'd0, '0},
            '{ROW_CFG, CFG_Y_LOW, 40'h0, 11'd0, 11'd0, '0},
            '{ROW_KNOWN, CFG_X_LOW, 40'h0, 11'd3, 11'd4, '{8'd0, 8'd0, 8'd0, 16'd0}},
            // zero bailout: only the origin iterates
            '{ROW_CFG, CFG_MAX_ITER, 40'd20, 11'd0, 11'd0, '0},
            '{ROW_CFG, CFG_BAILOUT, 40'd0, 11'd0, 11'd0, '0},
            '{ROW_KNOWN, CFG_X_LOW, 40'h0, 11'd7, 11'd7, '{8'd0, 8'd0, 8'd0, 16'd20}},
            '{ROW_CFG, CFG_X_STEP, 40'h7F_FFFF_FFFF, 11'd0, 11'd0, '0},
            '{ROW_KNOWN, CFG_X_LOW, 40'h0, 11'd2047, 11'd0, '{8'd0, 8'd0, 8'd0, 16'd0}},
            '{ROW_PIX, CFG_X_LOW, 40'h0, 11'd0, 11'd5, '0},
            '{ROW_CFG, CFG_Y_STEP, 40'h7F_FFFF_FFFF, 11'd0, 11'd0, '0},
            '{ROW_PIX, CFG_X_LOW, 40'h0, 11'd2047, 11'd2047, '0},
            // full view: x -2.5 .. 1.0, y -1.25 .. 1.25
            '{ROW_CFG, CFG_BAILOUT, 40'd31, 11'd0, 11'd0, '0},
            '{ROW_CFG, CFG_X_LOW, 40'hF6_0000_0000, 11'd0, 11'd0, '0},
            '{ROW_CFG, CFG_X_STEP, 40'h1C0_0000, 11'd0, 11'd0, '0},
            '{ROW_CFG, CFG_Y_LOW, 40'hFB_0000_0000, 11'd0, 11'd0, '0},
            '{ROW_CFG, CFG_Y_STEP, 40'h140_0000, 11'd0, 11'd0, '0},
            '{ROW_PIX, CFG_X_LOW, 40'h0, 11'd1024, 11'd1106, '0},
            '{ROW_PIX, CFG_X_LOW, 40'h0, 11'd0, 11'd0, '0},
            '{ROW_PIX, CFG_X_LOW, 40'h0, 11'd1462, 11'd1024, '0},
            '{ROW_PIX, CFG_X_LOW, 40'h0, 11'd600, 11'd1024, '0},
            '{ROW_PIX, CFG_X_LOW, 40'h0, 11'd1100, 11'd1900, '0},
            '{ROW_CFG, CFG_BAILOUT, 40'd16, 11'd0, 11'd0, '0},
            '{ROW_PIX, CFG_X_LOW, 40'h0, 11'd1638, 11'd1024, '0},
            '{ROW_PIX, CFG_X_LOW, 40'h0, 11'd300, 11'd1500, '0},
            // green scale at both ends
            '{ROW_CFG, CFG_INV_ZOOM, 40'hFF_FFFF, 11'd0, 11'd0, '0},
            '{ROW_PIX, CFG_X_LOW, 40'h0, 11'd1024, 11'd1106, '0},
            '{ROW_PIX, CFG_X_LOW, 40'h0, 11'd1638, 11'd1024, '0},
            '{ROW_CFG, CFG_INV_ZOOM, 40'h0, 11'd0, 11'd0, '0},
            '{ROW_PIX, CFG_X_LOW, 40'h0, 11'd1638, 11'd1024, '0},
            '{ROW_CFG, CFG_BAILOUT, 40'd1, 11'd0, 11'd0, '0},
            '{ROW_PIX, CFG_X_LOW, 40'h0, 11'd1500, 11'd1000, '0},
            '{ROW_CFG, CFG_MAX_ITER, 40'd1, 11'd0, 11'd0, '0},
            '{ROW_PIX, CFG_X_LOW, 40'h0, 11'd1024, 11'd1106, '0}
        };
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (n = 0; n < SCRIPT_ROWS; n++) begin
            r = script[n];
            if (r.kind == ROW_CFG) begin
                finish_frame();
                write_reg(r.idx, r.value);
            end else begin
                send_pixel(r.col, r.row, r.kind == ROW_KNOWN, r.shade);
            end
        end

        sent = 0;
        phase = 0;
        while (sent < RANDOM_PIXELS) begin
            finish_frame();
            calm = ($urandom_range(0, 3) == 0);
            // one frame with long iteration limits, kept short
            pick_settings(phase == 2);
            lot = (phase == 2) ? 5 : $urandom_range(10, 40);
            repeat (lot) begin
                send_pixel(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)), 1'b0, '0);
            end
            sent += lot;
            phase++;
        end

        finish_frame();
        repeat (800) @(posedge i_clk);
        if (faults == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin : watchdog
        #60_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
rtl/core/mep_pkg.sv
rtl/core/mep_mul.sv
rtl/core/mep_acc.sv
rtl/core/mandelbrot_escape_pixel_top.sv
bench/tb_top.sv
